// ----- hdl/hamming_knn_search_defines.svh -----
// Assertion macros shared by the search block's checking code.
`ifndef HAMMING_KNN_SEARCH_DEFINES_SVH
`define HAMMING_KNN_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define HKS_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define HKS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/hks_pkg.sv -----
// Shared constants, types and sequencer states of the Hamming k-NN search block.
package hks_pkg;

	// default sizes
	localparam int MAX_ENTRIES_DEF  = 256;
	localparam int VECTOR_WORDS_DEF = 16;
	localparam int KEEP_MAX_DEF     = 16;

	// field widths
	localparam int WORD_W      = 64;
	localparam int ENTRY_IDX_W = 8;
	localparam int WORD_IDX_W  = 4;
	localparam int DIST_W      = 11;
	localparam int KEEP_CNT_W  = 5;   // holds a list size up to the largest KEEP_MAX
	localparam int ENTRIES_W   = 9;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 9;

	// stream word layout
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 8;

	// request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBORS_WANTED = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_UPDATE,
		ST_EMIT
	} hks_state_t;

	// request from the sequencer to the keep list
	typedef struct packed {
		logic                   clear;
		logic                   upd;
		logic [ENTRY_IDX_W-1:0] index;
		logic [DIST_W-1:0]      distance;
		logic [KEEP_CNT_W-1:0]  keep;
	} hks_list_cmd_t;

	// keep list status back to the sequencer
	typedef struct packed {
		logic                  busy;
		logic [KEEP_CNT_W-1:0] count;
	} hks_list_sts_t;

endpackage

// ----- hdl/hks_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hks_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/hks_dist.sv -----
// Distance unit: popcount of one XORed word per cycle, accumulated over a vector.
module hks_dist (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_first,
	input  logic                       in_last,
	input  logic [hks_pkg::WORD_W-1:0] qword,
	input  logic [hks_pkg::WORD_W-1:0] sword,
	output logic [hks_pkg::DIST_W-1:0] distance,
	output logic                       done
);

	import hks_pkg::*;

	localparam int POP_W = $clog2(WORD_W + 1);

	// byte-wise popcount, then sum of the eight byte counts
	function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] x);
		logic [POP_W-1:0] sum;
		logic [3:0]       b;
		sum = '0;
		for (int i = 0; i < WORD_W / 8; i++) begin
			b = '0;
			for (int j = 0; j < 8; j++) begin
				b = b + 4'(x[i*8+j]);
			end
			sum = sum + POP_W'(b);
		end
		return sum;
	endfunction

	logic [POP_W-1:0]  pop_s2;
	logic              valid_s2;
	logic              first_s2;
	logic              last_s2;
	logic [DIST_W-1:0] acc_q;
	logic              done_q;

	// stage 2: popcount of the differing bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		pop_s2   <= pop64(qword ^ sword);
		first_s2 <= in_first;
		last_s2  <= in_last;
	end

	// accumulate; done pulses once the last word is in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2 & last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) + DIST_W'(pop_s2);
		end
	end

	assign distance = acc_q;
	assign done     = done_q;

endmodule

// ----- hdl/hks_list.sv -----
// Keep list: best indices and distances, with a slot-by-slot search for the worst slot.
module hks_list #(
	parameter int KEEP_MAX = hks_pkg::KEEP_MAX_DEF,
	localparam int SLOT_W = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hks_pkg::hks_list_cmd_t          cmd,
	input  logic [SLOT_W-1:0]               emit_ptr,
	output hks_pkg::hks_list_sts_t          sts,
	output logic [hks_pkg::ENTRY_IDX_W-1:0] rd_index
);

	import hks_pkg::*;

	localparam int KEEP_CW = $clog2(KEEP_MAX + 1);

	logic [ENTRY_IDX_W-1:0] idx_q  [KEEP_MAX];
	logic [DIST_W-1:0]      dist_q [KEEP_MAX];

	logic [KEEP_CW-1:0] count_q;
	logic               busy_q;
	logic [SLOT_W-1:0]  scan_ptr_q;
	logic [SLOT_W-1:0]  cand_slot_q;
	logic [DIST_W-1:0]  cand_dist_q;
	logic [SLOT_W-1:0]  worst_slot_q;
	logic [DIST_W-1:0]  worst_dist_q;

	logic [KEEP_CW-1:0] keep;
	logic [SLOT_W-1:0]  rd_ptr;
	logic [DIST_W-1:0]  rd_dist;
	logic               greater;
	logic               scan_end;
	logic               do_append;
	logic               do_replace;
	logic [SLOT_W-1:0]  wr_slot;

	assign keep = KEEP_CW'(cmd.keep);

	// one read port: the worst-slot search owns it while busy
	assign rd_ptr   = busy_q ? scan_ptr_q : emit_ptr;
	assign rd_dist  = dist_q[rd_ptr];
	assign rd_index = idx_q[rd_ptr];

	// shared compare: first slot of greatest distance wins
	assign greater  = (scan_ptr_q == '0) || (rd_dist > cand_dist_q);
	assign scan_end = KEEP_CW'(scan_ptr_q) == count_q - 1'b1;

	assign do_append  = cmd.upd && (count_q < keep);
	assign do_replace = cmd.upd && !(count_q < keep) && (cmd.distance < worst_dist_q);
	assign wr_slot    = do_append ? SLOT_W'(count_q) : worst_slot_q;

	// fill count and search control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			busy_q  <= 1'b0;
		end else if (do_append) begin
			count_q <= count_q + 1'b1;
			busy_q  <= (count_q + 1'b1) == keep;
		end else if (do_replace) begin
			busy_q <= 1'b1;
		end else if (busy_q && scan_end) begin
			busy_q <= 1'b0;
		end
	end

	// search walk and list contents
	always_ff @(posedge clk) begin
		if (do_append || do_replace) begin
			idx_q[wr_slot]  <= cmd.index;
			dist_q[wr_slot] <= cmd.distance;
			scan_ptr_q      <= '0;
		end else if (busy_q) begin
			scan_ptr_q <= scan_ptr_q + 1'b1;
			if (greater) begin
				cand_slot_q <= scan_ptr_q;
				cand_dist_q <= rd_dist;
			end
			if (scan_end) begin
				worst_slot_q <= greater ? scan_ptr_q : cand_slot_q;
				worst_dist_q <= greater ? rd_dist : cand_dist_q;
			end
		end
	end

	assign sts.busy  = busy_q;
	assign sts.count = KEEP_CNT_W'(count_q);

endmodule

// ----- hdl/hamming_knn_search.sv -----
// Top level of the Hamming k-NN search block: stream ports, store, sequencer.
//
// Input stream (s_*): one word per accepted beat. s_tuser selects a store write
// (0) or a query word (1); s_tdata carries entry, word position and 64 data bits.
// A store write or a non-final query word gives no result and leaves the block idle.
// The query word at position VECTOR_WORDS-1 starts a search: s_tready drops and
// every live entry is read word by word through one popcount/accumulate unit.
// Once the list is full, each list change starts a search for the worst slot, one
// slot a cycle, in the shadow of the next entry. After the last entry, results go
// out one word per cycle on m_* while the receiver accepts them (kept indices in
// list order, tlast on the final one, or one no-match word with tuser set).
// s_tready returns once the final result is loaded, even while it still waits in
// the output register. A receiver stall holds the output register and pauses
// result delivery. The user must write configuration (cfg_*) only while idle;
// the block does not enforce it. Reset clears control state, sets entries_in_use
// to 0 and neighbors_wanted to 1; stored vectors are undefined until written.
`include "hamming_knn_search_defines.svh"

module hamming_knn_search #(
	parameter int MAX_ENTRIES  = hks_pkg::MAX_ENTRIES_DEF,
	parameter int VECTOR_WORDS = hks_pkg::VECTOR_WORDS_DEF,
	parameter int KEEP_MAX     = hks_pkg::KEEP_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// s_tdata: entry_index[7:0], word_index[11:8], vector_word[75:12], zero pad
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [hks_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,   // req_type
	// m_tdata: match_index[7:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [hks_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tlast,   // last
	output logic                           m_tuser,   // no_match
	input  logic                           cfg_we,
	input  logic [hks_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hks_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	import hks_pkg::*;

	localparam int DEPTH   = MAX_ENTRIES * VECTOR_WORDS;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WORD_CW = (VECTOR_WORDS > 1) ? $clog2(VECTOR_WORDS) : 1;
	localparam int ENT_CW  = $clog2(MAX_ENTRIES + 1);
	localparam int KEEP_CW = $clog2(KEEP_MAX + 1);
	localparam int SLOT_W  = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;

	// input word fields
	logic                   in_type;
	logic [ENTRY_IDX_W-1:0] in_entry;
	logic [WORD_IDX_W-1:0]  in_word;
	logic [WORD_W-1:0]      in_vword;
	logic                   in_fire;
	logic                   word_ok;
	logic                   qbuf_we;
	logic                   start;

	assign in_type  = s_tuser;
	assign in_entry = s_tdata[ENTRY_IDX_W-1:0];
	assign in_word  = s_tdata[ENTRY_IDX_W +: WORD_IDX_W];
	assign in_vword = s_tdata[ENTRY_IDX_W + WORD_IDX_W +: WORD_W];

	// configuration registers
	logic [ENTRIES_W-1:0]  entries_in_use_q;
	logic [KEEP_CNT_W-1:0] neighbors_wanted_q;
	logic [ENT_CW-1:0]     n_sat;
	logic [KEEP_CW-1:0]    k_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q   <= '0;
			neighbors_wanted_q <= KEEP_CNT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENTRIES_IN_USE:   entries_in_use_q   <= cfg_wdata[ENTRIES_W-1:0];
				CFG_NEIGHBORS_WANTED: neighbors_wanted_q <= cfg_wdata[KEEP_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign n_sat = (int'(entries_in_use_q) > MAX_ENTRIES) ? ENT_CW'(MAX_ENTRIES)
	                                                      : ENT_CW'(entries_in_use_q);
	assign k_sat = (int'(neighbors_wanted_q) > KEEP_MAX) ? KEEP_CW'(KEEP_MAX)
	                                                     : KEEP_CW'(neighbors_wanted_q);

	// sequencer state and counters
	hks_state_t            state_q, state_d;
	logic [ENT_CW-1:0]     entry_q;
	logic [ENT_CW-1:0]     n_q;
	logic [KEEP_CNT_W-1:0] k_q;
	logic [WORD_CW-1:0]    word_q;
	logic [ADDR_W-1:0]     addr_q;
	logic                  empty_q;
	logic [KEEP_CW-1:0]    emit_ptr_q;

	logic word_last;
	logic entry_last;
	logic ram_re;
	logic out_load;
	logic out_final;

	hks_list_cmd_t list_cmd;
	hks_list_sts_t list_sts;
	logic [ENTRY_IDX_W-1:0] list_rd_index;

	logic [DIST_W-1:0] distance;
	logic              dist_done;

	assign in_fire    = s_tvalid & s_tready;
	assign word_ok    = int'(in_word) < VECTOR_WORDS;
	assign qbuf_we    = in_fire && word_ok && (in_type == REQ_QUERY);
	assign start      = qbuf_we && (int'(in_word) == VECTOR_WORDS - 1);
	assign word_last  = int'(word_q) == VECTOR_WORDS - 1;
	assign entry_last = entry_q == n_q - 1'b1;
	assign out_final  = empty_q ||
	                    (KEEP_CNT_W'(emit_ptr_q) + KEEP_CNT_W'(1) == list_sts.count);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ((k_sat == '0) || (n_sat == '0)) ? ST_EMIT : ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (word_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (dist_done) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!list_sts.busy) state_d = entry_last ? ST_EMIT : ST_ISSUE;
			end
			ST_EMIT: begin
				if (out_load && out_final) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready          = 1'b0;
		ram_re            = 1'b0;
		out_load          = 1'b0;
		list_cmd.clear    = start;
		list_cmd.upd      = 1'b0;
		list_cmd.index    = ENTRY_IDX_W'(entry_q);
		list_cmd.distance = distance;
		list_cmd.keep     = k_q;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_ISSUE:  ram_re = 1'b1;
			ST_DRAIN:  ;
			ST_UPDATE: list_cmd.upd = !list_sts.busy;
			ST_EMIT:   out_load = !list_sts.busy && (!m_tvalid || m_tready);
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q    <= '0;
			n_q        <= '0;
			k_q        <= '0;
			word_q     <= '0;
			addr_q     <= '0;
			empty_q    <= 1'b0;
			emit_ptr_q <= '0;
		end else begin
			if (start) begin
				entry_q    <= '0;
				n_q        <= n_sat;
				k_q        <= KEEP_CNT_W'(k_sat);
				word_q     <= '0;
				addr_q     <= '0;
				empty_q    <= (k_sat == '0) || (n_sat == '0);
				emit_ptr_q <= '0;
			end
			if (ram_re) begin
				addr_q <= addr_q + 1'b1;
				word_q <= word_last ? '0 : word_q + 1'b1;
			end
			if (list_cmd.upd) begin
				entry_q <= entry_q + 1'b1;
			end
			if (out_load) begin
				emit_ptr_q <= emit_ptr_q + 1'b1;
			end
		end
	end

	// query buffer
	logic [WORD_W-1:0] qbuf_q [VECTOR_WORDS];

	always_ff @(posedge clk) begin
		if (qbuf_we) begin
			qbuf_q[in_word[WORD_CW-1:0]] <= in_vword;
		end
	end

	// vector store
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_rdata;

	assign ram_we    = in_fire && word_ok && (in_type == REQ_WRITE) &&
	                   (int'(in_entry) < MAX_ENTRIES);
	assign ram_waddr = ADDR_W'(int'(in_entry) * VECTOR_WORDS + int'(in_word));

	hks_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(in_vword),
		.re   (ram_re),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	// stage 1: query word lined up with the store read data
	logic              valid_s1;
	logic              first_s1;
	logic              last_s1;
	logic [WORD_W-1:0] qword_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= word_q == '0;
		last_s1  <= word_last;
		qword_s1 <= qbuf_q[word_q];
	end

	hks_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(valid_s1),
		.in_first(first_s1),
		.in_last (last_s1),
		.qword   (qword_s1),
		.sword   (ram_rdata),
		.distance(distance),
		.done    (dist_done)
	);

	hks_list #(
		.KEEP_MAX(KEEP_MAX)
	) u_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (list_cmd),
		.emit_ptr(SLOT_W'(emit_ptr_q)),
		.sts     (list_sts),
		.rd_index(list_rd_index)
	);

	// output register
	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;
	logic                   m_tlast_q;
	logic                   m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= empty_q ? '0 : M_TDATA_W'(list_rd_index);
			m_tlast_q <= out_final;
			m_tuser_q <= empty_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	// checks
	`HKS_ASSERT_SAME(a_count_within_keep, state_q != ST_IDLE, list_sts.count <= k_q, "keep list overfilled")
	`HKS_ASSERT_SAME(a_nomatch_is_last, m_tvalid && m_tuser, m_tlast, "no-match word without tlast")
	`HKS_ASSERT_SAME(a_done_in_drain, dist_done, state_q == ST_DRAIN, "distance done outside drain")
	`HKS_ASSERT_NEXT(a_clear_empties, list_cmd.clear, list_sts.count == '0 && !list_sts.busy, "list not cleared")

endmodule
